// File: sv/mrh_pkg.sv
package mrh_pkg;

  // Protocol constants
  localparam logic [7:0]  FuncReadHolding = 8'h03;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;
  localparam logic [15:0] MaxRegs         = 16'd125;
  localparam logic [15:0] TimeoutReset    = 16'd1000;
  localparam logic [8:0]  HeaderBytes     = 9'd5;
  localparam logic [8:0]  CrcBytes        = 9'd2;

  // Input item operations
  typedef enum logic [1:0] {
    OpStart  = 2'd0,
    OpRxByte = 2'd1,
    OpTick   = 2'd2
  } mrh_op_e;

  // Result item kinds
  typedef enum logic [1:0] {
    KindTx     = 2'd0,
    KindReg    = 2'd1,
    KindStatus = 2'd2
  } mrh_kind_e;

  // Final status codes
  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StInvalid = 3'd1,
    StTimeout = 3'd2,
    StCrcErr  = 3'd3,
    StHdrErr  = 3'd4
  } mrh_status_e;

  // Transaction phase, one-hot
  typedef enum logic [1:0] {
    PhIdle = 2'b01,
    PhWait = 2'b10
  } mrh_phase_e;

  // What an accepted item leaves for the output side
  typedef enum logic [1:0] {
    BmNone    = 2'd0,
    BmSingle  = 2'd1,
    BmRequest = 2'd2
  } mrh_bmode_e;

  typedef struct packed {
    mrh_bmode_e  mode;
    mrh_kind_e   kind;
    mrh_status_e status;
    logic        last;
    logic [6:0]  reg_pos;
    logic [15:0] reg_value;
    logic [7:0]  slave;
    logic [15:0] addr;
    logic [15:0] count;
  } mrh_bundle_t;

  // One byte of CRC-16, reflected polynomial
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/modbus_rtu_read_holding_master_core.sv
// Modbus RTU master for function 03 (read holding registers). A start item
// yields eight request bytes, one output item per cycle unless out_stall_i
// holds it, with drive_enable_o high; received bytes and millisecond ticks
// are then matched against the response, giving one register value per low
// byte and one final status. Each input item updates the state in the cycle
// it is taken; the only limit on the input rate is the output register,
// which holds a start's request for eight output transfers (the request CRC
// is folded in one byte per transfer) and any other result for one. Input
// is stalled only while the output still holds items that will not all have
// gone by the end of the current cycle. The timeout register is written with
// cfg_we_i and resets to 1000 ms.
module modbus_rtu_read_holding_master_core import mrh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  slave_id_i,
  input  logic [15:0] start_addr_i,
  input  logic [15:0] reg_count_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        drive_enable_o,
  output logic [6:0]  reg_pos_o,
  output logic [15:0] reg_value_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  mrh_bundle_t bundle;
  logic        ready;
  logic        accept;

  assign in_stall_o = !ready;
  assign accept     = in_valid_i && ready;

  mrh_proto u_proto (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .op_i         (op_i),
    .slave_id_i   (slave_id_i),
    .start_addr_i (start_addr_i),
    .reg_count_i  (reg_count_i),
    .rx_byte_i    (rx_byte_i),
    .bundle_o     (bundle)
  );

  mrh_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (accept),
    .bundle_i       (bundle),
    .ready_o        (ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .tx_byte_o      (tx_byte_o),
    .drive_enable_o (drive_enable_o),
    .reg_pos_o      (reg_pos_o),
    .reg_value_o    (reg_value_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule

// File: sv/mrh_proto.sv
module mrh_proto import mrh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        accept_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  slave_id_i,
  input  logic [15:0] start_addr_i,
  input  logic [15:0] reg_count_i,
  input  logic [7:0]  rx_byte_i,
  output mrh_bundle_t bundle_o
);

  mrh_phase_e  phase_q, phase_d;
  logic [15:0] timeout_q;
  logic [7:0]  nrx_q, nrx_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  slave_q, slave_d;
  logic [6:0]  count_q, count_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [7:0]  pend_q, pend_d;
  logic        hdr_ok_q, hdr_ok_d;

  logic        busy;
  logic [8:0]  nrx9;
  logic [8:0]  expect9;
  logic [15:0] el_inc;
  logic [7:0]  idx8;
  logic [6:0]  idx;
  logic [15:0] rx_crc;

  assign busy    = (phase_q == PhWait);
  assign nrx9    = {1'b0, nrx_q};
  assign expect9 = HeaderBytes + {1'b0, count_q, 1'b0};
  assign el_inc  = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign idx8    = nrx_q - 8'd4;
  assign idx     = idx8[7:1];
  assign rx_crc  = {rx_byte_i, pend_q};

  // Decode the item, update transaction state and build the result bundle
  always_comb begin
    phase_d   = phase_q;
    nrx_d     = nrx_q;
    crc_d     = crc_q;
    slave_d   = slave_q;
    count_d   = count_q;
    elapsed_d = elapsed_q;
    pend_d    = pend_q;
    hdr_ok_d  = hdr_ok_q;

    bundle_o           = '0;
    bundle_o.mode      = BmNone;
    bundle_o.kind      = KindStatus;
    bundle_o.status    = StOk;
    bundle_o.last      = 1'b1;
    bundle_o.slave     = slave_id_i;
    bundle_o.addr      = start_addr_i;
    bundle_o.count     = reg_count_i;

    if (accept_i) begin
      unique case (op_i)
        OpStart: begin
          if (busy || reg_count_i == 16'd0 || reg_count_i > MaxRegs ||
              timeout_q == 16'd0) begin
            bundle_o.mode   = BmSingle;
            bundle_o.status = StInvalid;
          end else begin
            bundle_o.mode = BmRequest;
            bundle_o.kind = KindTx;
            phase_d       = PhWait;
            slave_d       = slave_id_i;
            count_d       = reg_count_i[6:0];
            nrx_d         = 8'd0;
            crc_d         = CrcInit;
            elapsed_d     = 16'd0;
            pend_d        = 8'd0;
            hdr_ok_d      = 1'b1;
          end
        end
        OpTick: begin
          if (busy) begin
            elapsed_d = el_inc;
            if (el_inc >= timeout_q) begin
              phase_d         = PhIdle;
              bundle_o.mode   = BmSingle;
              bundle_o.status = StTimeout;
            end
          end
        end
        OpRxByte: begin
          if (busy) begin
            nrx_d = nrx_q + 8'd1;
            if (nrx9 + CrcBytes < expect9) begin
              // Body byte: covered by the CRC
              crc_d = crc16_byte(crc_q, rx_byte_i);
              if (nrx_q == 8'd0 && rx_byte_i != slave_q) hdr_ok_d = 1'b0;
              if (nrx_q == 8'd1 && rx_byte_i != FuncReadHolding) hdr_ok_d = 1'b0;
              if (nrx_q == 8'd2 && rx_byte_i != {count_q, 1'b0}) hdr_ok_d = 1'b0;
              if (nrx_q >= 8'd3) begin
                if (nrx_q[0]) begin
                  pend_d = rx_byte_i;
                end else begin
                  bundle_o.mode      = BmSingle;
                  bundle_o.kind      = KindReg;
                  bundle_o.reg_pos   = idx;
                  bundle_o.reg_value = {pend_q, rx_byte_i};
                  bundle_o.last      = ({1'b0, idx} + 8'd1 == {1'b0, count_q});
                end
              end
            end else if (nrx9 + CrcBytes == expect9) begin
              // CRC low byte
              pend_d = rx_byte_i;
            end else begin
              // CRC high byte: judge the response
              phase_d       = PhIdle;
              bundle_o.mode = BmSingle;
              if (rx_crc != crc_q) begin
                bundle_o.status = StCrcErr;
              end else if (!hdr_ok_q) begin
                bundle_o.status = StHdrErr;
              end else begin
                bundle_o.status = StOk;
              end
            end
          end
        end
        default: begin
          bundle_o.mode = BmNone;
        end
      endcase
    end
  end

  // Hold state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      timeout_q <= TimeoutReset;
      nrx_q     <= 8'd0;
      crc_q     <= CrcInit;
      slave_q   <= 8'd0;
      count_q   <= 7'd0;
      elapsed_q <= 16'd0;
      pend_q    <= 8'd0;
      hdr_ok_q  <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      nrx_q     <= nrx_d;
      crc_q     <= crc_d;
      slave_q   <= slave_d;
      count_q   <= count_d;
      elapsed_q <= elapsed_d;
      pend_q    <= pend_d;
      hdr_ok_q  <= hdr_ok_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// File: sv/mrh_emit.sv
module mrh_emit import mrh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  mrh_bundle_t bundle_i,
  output logic        ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        drive_enable_o,
  output logic [6:0]  reg_pos_o,
  output logic [15:0] reg_value_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  mrh_bundle_t bundle_q;
  logic        valid_q, valid_d;
  logic [2:0]  beat_q, beat_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  req_byte;
  logic        take;
  logic        done;

  assign take    = valid_q && !out_stall_i;
  assign done    = take && (bundle_q.mode != BmRequest || beat_q == 3'd7);
  assign ready_o = !valid_q || done;

  // Select the request byte for the current beat
  always_comb begin
    unique case (beat_q)
      3'd0:    req_byte = bundle_q.slave;
      3'd1:    req_byte = FuncReadHolding;
      3'd2:    req_byte = bundle_q.addr[15:8];
      3'd3:    req_byte = bundle_q.addr[7:0];
      3'd4:    req_byte = bundle_q.count[15:8];
      3'd5:    req_byte = bundle_q.count[7:0];
      3'd6:    req_byte = crc_q[7:0];
      default: req_byte = crc_q[15:8];
    endcase
  end

  // Advance the beat counter and the request CRC
  always_comb begin
    valid_d = valid_q;
    beat_d  = beat_q;
    crc_d   = crc_q;
    if (load_i) begin
      valid_d = (bundle_i.mode != BmNone);
      beat_d  = 3'd0;
      crc_d   = CrcInit;
    end else if (done) begin
      valid_d = 1'b0;
    end else if (take) begin
      beat_d = beat_q + 3'd1;
      if (beat_q < 3'd6) begin
        crc_d = crc16_byte(crc_q, req_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= 3'd0;
      crc_q   <= CrcInit;
    end else begin
      valid_q <= valid_d;
      beat_q  <= beat_d;
      crc_q   <= crc_d;
    end
  end

  // Hold the bundle until its last item is taken
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bundle_q <= bundle_i;
    end
  end

  // Drive the result fields
  assign out_valid_o = valid_q;

  always_comb begin
    kind_o         = KindStatus;
    tx_byte_o      = 8'd0;
    drive_enable_o = 1'b0;
    reg_pos_o      = 7'd0;
    reg_value_o    = 16'd0;
    status_o       = StOk;
    last_o         = 1'b0;
    unique case (bundle_q.mode)
      BmRequest: begin
        kind_o         = KindTx;
        tx_byte_o      = req_byte;
        drive_enable_o = 1'b1;
        last_o         = (beat_q == 3'd7);
      end
      BmSingle: begin
        kind_o      = bundle_q.kind;
        reg_pos_o   = bundle_q.reg_pos;
        reg_value_o = bundle_q.reg_value;
        status_o    = bundle_q.status;
        last_o      = bundle_q.last;
      end
      default: begin
        last_o = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/mrh_checker.sv
module mrh_checker import mrh_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  kind_o,
  input logic        drive_enable_o,
  input logic        last_o
);

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // Input is only held off while a result is pending
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i || out_valid_o && !last_o)
    else $error("input stalled with nothing pending");

  // The driver is enabled exactly for request bytes
  a_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_enable_o == (kind_o == KindTx)))
    else $error("drive enable does not match item kind");

  // Every status item is marked last
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindStatus |-> last_o)
    else $error("status item without last");

endmodule

bind modbus_rtu_read_holding_master_core mrh_checker u_mrh_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mrh_pkg::*;

  // Operation code the block has no use for
  localparam logic [1:0] OpUnused = 2'd3;
  // Cycles with no item moving on either side before the run is abandoned
  localparam int QuietLimit = 2000;
  // Cycles allowed for the block to settle once nothing is awaited
  localparam int SettleCycles = 4;
  // Input items per random phase that the block acts on
  localparam int PhaseItems = 70;

  typedef struct {
    mrh_kind_e   kind;
    logic [7:0]  tx_byte;
    logic        drive_enable;
    logic [6:0]  reg_pos;
    logic [15:0] reg_value;
    mrh_status_e status;
    logic        last;
  } master_out_t;

  // Where a directed row takes its received byte from
  typedef enum logic [1:0] {
    RxGiven,
    RxCrcLow,
    RxCrcHigh
  } rx_src_e;

  typedef struct {
    bit          wr_cfg;
    logic [15:0] cfg_value;
    logic [1:0]  op;
    logic [7:0]  slave;
    logic [15:0] addr;
    logic [15:0] count;
    rx_src_e     rx_src;
    logic [7:0]  rx;
    bit          fixed;
    mrh_status_e fixed_status;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = OpTick;
  logic [7:0]  slave_id_i = '0;
  logic [15:0] start_addr_i = '0;
  logic [15:0] reg_count_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  tx_byte_o;
  logic        drive_enable_o;
  logic [6:0]  reg_pos_o;
  logic [15:0] reg_value_o;
  logic [2:0]  status_o;
  logic        last_o;

  // Mirror of the master's state and timeout register
  bit          busy = 1'b0;
  logic [7:0]  rx_count = '0;
  logic [15:0] frame_crc = CrcInit;
  logic [7:0]  slave_seen = '0;
  logic [6:0]  count_saved = '0;
  logic [15:0] ms_elapsed = '0;
  logic [7:0]  held_byte = '0;
  bit          header_good = 1'b1;
  logic [15:0] resp_timeout = TimeoutReset;

  master_out_t awaited_outputs[$];
  master_out_t step_outputs[$];
  master_out_t head_out;
  stim_row_t   stim_table[$];

  int mismatches = 0;
  int quiet = 0;
  int taken_total = 0;
  int taken_seen = 0;
  int stall_left = 0;
  int items_used = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  bit big_done = 1'b0;

  modbus_rtu_read_holding_master_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .slave_id_i     (slave_id_i),
    .start_addr_i   (start_addr_i),
    .reg_count_i    (reg_count_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .tx_byte_o      (tx_byte_o),
    .drive_enable_o (drive_enable_o),
    .reg_pos_o      (reg_pos_o),
    .reg_value_o    (reg_value_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // Fold one byte into a Modbus CRC, least significant bit first
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    repeat (8) acc = acc[0] ? ({1'b0, acc[15:1]} ^ CrcPoly) : {1'b0, acc[15:1]};
    return acc;
  endfunction

  function automatic master_out_t make_out(mrh_kind_e kind, logic [7:0] tx, logic de,
                                           logic [6:0] idx, logic [15:0] val,
                                           mrh_status_e st, logic last);
    master_out_t o;
    o.kind = kind;
    o.tx_byte = tx;
    o.drive_enable = de;
    o.reg_pos = idx;
    o.reg_value = val;
    o.status = st;
    o.last = last;
    return o;
  endfunction

  function automatic master_out_t status_out(mrh_status_e st);
    return make_out(KindStatus, 8'h00, 1'b0, 7'd0, 16'd0, st, 1'b1);
  endfunction

  // Advance the mirrored master by one input item; leave its outputs in
  // step_outputs and return whether the item was acted on
  function automatic bit compute_master_outputs(logic [1:0] op, logic [7:0] slave,
                                                logic [15:0] addr, logic [15:0] count,
                                                logic [7:0] rx);
    logic [7:0]  req [8];
    logic [15:0] crc;
    logic [8:0]  frame_len;
    logic [8:0]  n;
    logic [8:0]  idx;
    step_outputs.delete();
    if (op == OpStart) begin
      if (busy || count == 16'd0 || count > MaxRegs || resp_timeout == 16'd0) begin
        step_outputs.push_back(status_out(StInvalid));
        return 1'b1;
      end
      req[0] = slave;
      req[1] = FuncReadHolding;
      req[2] = addr[15:8];
      req[3] = addr[7:0];
      req[4] = count[15:8];
      req[5] = count[7:0];
      crc = CrcInit;
      for (int i = 0; i < 6; i++) crc = crc16_update(crc, req[i]);
      req[6] = crc[7:0];
      req[7] = crc[15:8];
      for (int i = 0; i < 8; i++) begin
        step_outputs.push_back(make_out(KindTx, req[i], 1'b1, 7'd0, 16'd0, StOk, i == 7));
      end
      busy = 1'b1;
      slave_seen = slave;
      count_saved = count[6:0];
      rx_count = '0;
      frame_crc = CrcInit;
      ms_elapsed = '0;
      held_byte = '0;
      header_good = 1'b1;
      return 1'b1;
    end
    if (!busy) return 1'b0;
    if (op == OpTick) begin
      if (ms_elapsed != 16'hFFFF) ms_elapsed = ms_elapsed + 16'd1;
      if (ms_elapsed >= resp_timeout) begin
        busy = 1'b0;
        step_outputs.push_back(status_out(StTimeout));
      end
      return 1'b1;
    end
    if (op == OpRxByte) begin
      frame_len = HeaderBytes + {1'b0, count_saved, 1'b0};
      n = {1'b0, rx_count};
      if (n + CrcBytes < frame_len) begin
        // Header and data: fold into the CRC and judge the header bytes
        frame_crc = crc16_update(frame_crc, rx);
        if (n == 9'd0 && rx != slave_seen) header_good = 1'b0;
        if (n == 9'd1 && rx != FuncReadHolding) header_good = 1'b0;
        if (n == 9'd2 && rx != {count_saved, 1'b0}) header_good = 1'b0;
        if (n >= 9'd3) begin
          if (n[0]) begin
            held_byte = rx;
          end else begin
            idx = (n - 9'd4) >> 1;
            step_outputs.push_back(make_out(KindReg, 8'h00, 1'b0, idx[6:0], {held_byte, rx},
                                            StOk, (idx + 9'd1) == {2'b00, count_saved}));
          end
        end
      end else if (n + CrcBytes == frame_len) begin
        held_byte = rx;
      end else begin
        // Final byte: CRC is judged before the header
        busy = 1'b0;
        if ({rx, held_byte} != frame_crc) step_outputs.push_back(status_out(StCrcErr));
        else if (!header_good) step_outputs.push_back(status_out(StHdrErr));
        else step_outputs.push_back(status_out(StOk));
      end
      rx_count = rx_count + 8'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  // Present one item after a random gap and hold it until taken
  task automatic send_item(logic [1:0] op, logic [7:0] slave, logic [15:0] addr,
                           logic [15:0] count, logic [7:0] rx, bit keep);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i <= op;
    slave_id_i <= slave;
    start_addr_i <= addr;
    reg_count_i <= count;
    rx_byte_i <= rx;
    do @(posedge clk_i); while (in_stall_o);
    if (compute_master_outputs(op, slave, addr, count, rx)) items_used++;
    if (keep) foreach (step_outputs[k]) awaited_outputs.push_back(step_outputs[k]);
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Hold off the input until every awaited item has come out
  task automatic wait_drain();
    idle_input();
    while (awaited_outputs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    wait_drain();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    resp_timeout = value;
  endtask

  task automatic add_row(bit wr_cfg, logic [15:0] cfg_value, logic [1:0] op, logic [7:0] slave,
                         logic [15:0] addr, logic [15:0] count, rx_src_e src, logic [7:0] rx,
                         bit fixed, mrh_status_e fixed_status);
    stim_row_t r;
    r.wr_cfg = wr_cfg;
    r.cfg_value = cfg_value;
    r.op = op;
    r.slave = slave;
    r.addr = addr;
    r.count = count;
    r.rx_src = src;
    r.rx = rx;
    r.fixed = fixed;
    r.fixed_status = fixed_status;
    stim_table.push_back(r);
  endtask

  task automatic send_noise();
    logic [15:0] count;
    count = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
    send_item(2'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), count, 8'($urandom),
              1'b1);
  endtask

  // Close any open transaction: ticks where the timeout is short, else bytes
  task automatic finish_frame();
    while (busy) begin
      send_item((resp_timeout <= 16'd64) ? OpTick : OpRxByte, 8'($urandom), 16'($urandom),
                16'($urandom), 8'($urandom), 1'b1);
    end
  endtask

  // One request and a mostly well-formed response, with noise mixed in
  task automatic run_frame();
    int count;
    int nbytes;
    int stop_at;
    int pick;
    logic [7:0] slave;
    logic [7:0] b;
    logic [7:0] crc_flip_lo;
    logic [7:0] crc_flip_hi;
    finish_frame();
    pick = $urandom_range(0, 99);
    if (pick < 2 && !big_done) begin
      count = int'(MaxRegs);
      big_done = 1'b1;
    end else if (pick < 12) begin
      count = $urandom_range(1, 16);
    end else begin
      count = $urandom_range(1, 4);
    end
    slave = 8'($urandom);
    crc_flip_lo = 8'h00;
    crc_flip_hi = 8'h00;
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1) == 0) crc_flip_lo = 8'($urandom_range(1, 255));
      else crc_flip_hi = 8'($urandom_range(1, 255));
    end
    send_item(OpStart, slave, 16'($urandom), 16'(count), 8'($urandom), 1'b1);
    nbytes = 5 + 2 * count;
    stop_at = ($urandom_range(0, 99) < 8) ? $urandom_range(0, nbytes - 1) : nbytes;
    for (int k = 0; k < stop_at; k++) begin
      if ($urandom_range(0, 99) < 10) send_item(OpTick, 8'($urandom), 16'($urandom),
                                                16'($urandom), 8'($urandom), 1'b1);
      if ($urandom_range(0, 99) < 4) send_noise();
      b = 8'($urandom);
      if (k == 0 && $urandom_range(0, 99) < 95) b = slave;
      if (k == 1 && $urandom_range(0, 99) < 95) b = FuncReadHolding;
      if (k == 2 && $urandom_range(0, 99) < 95) b = 8'(2 * count);
      if (k == nbytes - 2) b = frame_crc[7:0] ^ crc_flip_lo;
      if (k == nbytes - 1) b = frame_crc[15:8] ^ crc_flip_hi;
      send_item(OpRxByte, 8'($urandom), 16'($urandom), 16'($urandom), b, 1'b1);
    end
  endtask

  // Compare each item taken from the block with the oldest one awaited
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      taken_total++;
      if (awaited_outputs.size() == 0) begin
        flag_mismatch($sformatf("unexpected item, kind %0d", kind_o));
      end else begin
        head_out = awaited_outputs.pop_front();
        compare_field("kind", 16'(kind_o), 16'(head_out.kind));
        compare_field("tx_byte", 16'(tx_byte_o), 16'(head_out.tx_byte));
        compare_field("drive_enable", 16'(drive_enable_o), 16'(head_out.drive_enable));
        compare_field("reg_pos", 16'(reg_pos_o), 16'(head_out.reg_pos));
        compare_field("reg_value", reg_value_o, head_out.reg_value);
        compare_field("status", 16'(status_o), 16'(head_out.status));
        compare_field("last", 16'(last_o), 16'(head_out.last));
      end
    end
  end

  // Stall the output side for a fresh random count after each item taken
  always @(negedge clk_i) begin
    if (taken_total != taken_seen) begin
      taken_seen = taken_total;
      stall_left = draw_wait(rx_calm);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Abandon the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t   row;
    logic [7:0]  rx_pick;
    int          phase_goal;
    int          run_start;

    // Idle-state items, bad counts, a clean frame with a start while busy,
    // a frame with a wrong slave, a timeout and a zero timeout
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'h55, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpTick,   8'h00, 16'h0000, 16'd0,    RxGiven,   8'h00, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpUnused, 8'hA5, 16'h5A5A, 16'd3,    RxGiven,   8'hC3, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpStart,  8'h01, 16'h0000, 16'd0,    RxGiven,   8'h00, 1'b1,
            StInvalid);
    add_row(1'b0, 16'd0, OpStart,  8'h01, 16'h0000, 16'd126,  RxGiven,   8'h00, 1'b1,
            StInvalid);
    add_row(1'b0, 16'd0, OpStart,  8'hFF, 16'hFFFF, 16'hFFFF, RxGiven,   8'hFF, 1'b1,
            StInvalid);
    add_row(1'b0, 16'd0, OpStart,  8'h00, 16'h0000, 16'd1,    RxGiven,   8'h00, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpStart,  8'h22, 16'h0001, 16'd2,    RxGiven,   8'h00, 1'b1,
            StInvalid);
    add_row(1'b0, 16'd0, OpTick,   8'h00, 16'h0000, 16'd0,    RxGiven,   8'h00, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'h00, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'h03, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'h02, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'hFF, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'hFF, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxCrcLow,  8'h00, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxCrcHigh, 8'h00, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpStart,  8'hFF, 16'hFFFF, 16'd1,    RxGiven,   8'h00, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'hFE, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'h03, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'h02, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'h12, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxGiven,   8'h34, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxCrcLow,  8'h00, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpRxByte, 8'h00, 16'h0000, 16'd0,    RxCrcHigh, 8'h00, 1'b0, StOk);
    add_row(1'b1, 16'd1, OpStart,  8'hFF, 16'hFFFF, 16'd125,  RxGiven,   8'h00, 1'b0, StOk);
    add_row(1'b0, 16'd0, OpTick,   8'h00, 16'h0000, 16'd0,    RxGiven,   8'h00, 1'b1,
            StTimeout);
    add_row(1'b1, 16'd0, OpStart,  8'h5A, 16'h1234, 16'd7,    RxGiven,   8'h00, 1'b1,
            StInvalid);

    // Hold reset, then release it between edges
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (stim_table[r]) begin
      row = stim_table[r];
      if (row.wr_cfg) write_timeout(row.cfg_value);
      case (row.rx_src)
        RxCrcLow:  rx_pick = frame_crc[7:0];
        RxCrcHigh: rx_pick = frame_crc[15:8];
        default:   rx_pick = row.rx;
      endcase
      send_item(row.op, row.slave, row.addr, row.count, rx_pick, !row.fixed);
      if (row.fixed) awaited_outputs.push_back(status_out(row.fixed_status));
    end

    // Random phases, each with its own timeout and idling pattern; the goals
    // count from the start of the random part so that a long frame in one
    // phase shortens the ones after it
    run_start = items_used;
    for (int p = 0; p < 5; p++) begin
      finish_frame();
      case (p)
        0:       write_timeout(16'hFFFF);
        1:       write_timeout(16'($urandom_range(2, 12)));
        2:       write_timeout(16'd1);
        3:       write_timeout(16'($urandom_range(20, 60)));
        default: write_timeout(TimeoutReset);
      endcase
      tx_calm = (p == 1) || (p == 3);
      rx_calm = (p == 2) || (p == 3);
      phase_goal = run_start + (p + 1) * PhaseItems;
      while (items_used < phase_goal) begin
        if ($urandom_range(0, 99) < 5) wait_drain();
        if ($urandom_range(0, 99) < 20) send_noise();
        else run_frame();
      end
    end

    // Let everything drain, then judge the run
    wait_drain();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// File: files.f
sv/mrh_pkg.sv
sv/mrh_proto.sv
sv/mrh_emit.sv
sv/modbus_rtu_read_holding_master_core.sv
sv/mrh_checker.sv
sim/testbench.sv
